@@ rtl/core/hdis_pkg.sv @@
// Shared types and constants of the HID descriptor item scanner.
package hdis_pkg;

  // Field widths of a descriptor byte and of a scan result
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 4;
  localparam int unsigned StoreDepth = 8;
  localparam int unsigned IdxW       = $clog2(StoreDepth);

  // Usage page looks at the low 16 bits of an item value, report ID at the low 8 bits
  localparam int unsigned ValueW = 16;

  // Short item prefix fields
  localparam logic [1:0] SIZE_CODE_FOUR = 2'h3;
  localparam logic [1:0] ITEM_TYPE_GLOBAL = 2'h1;
  localparam logic [3:0] TAG_USAGE_PAGE = 4'h0;
  localparam logic [3:0] TAG_REPORT_ID  = 4'h8;

  // Usage pages of interest
  localparam logic [ValueW-1:0] PAGE_DESKTOP  = 16'h0001;
  localparam logic [ValueW-1:0] PAGE_KEYBOARD = 16'h0007;
  localparam logic [ValueW-1:0] PAGE_CONSUMER = 16'h000C;

  // Data bytes of the widest short item
  localparam logic [2:0] DATA_BYTES_MAX = 3'd4;

  // One registered descriptor byte
  typedef struct packed {
    logic [ByteW-1:0] desc_byte;
    logic             first_byte;
    logic             last_byte;
  } byte_t;

endpackage

@@ rtl/core/hdis_byte_if.sv @@
// Descriptor byte channel and scan result channel.
interface hdis_byte_if import hdis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] desc_byte;
  logic             first_byte;
  logic             last_byte;

  modport source (output valid, desc_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, desc_byte, first_byte, last_byte, output ready);
endinterface

interface hdis_result_if import hdis_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              has_keyboard;
  logic              has_cons_page;
  logic              has_desktop;
  logic [CountW-1:0] id_count;
  logic [ByteW-1:0]  report_id_0;
  logic [ByteW-1:0]  report_id_1;
  logic [ByteW-1:0]  report_id_2;
  logic [ByteW-1:0]  report_id_3;
  logic [ByteW-1:0]  report_id_4;
  logic [ByteW-1:0]  report_id_5;
  logic [ByteW-1:0]  report_id_6;
  logic [ByteW-1:0]  report_id_7;

  modport source (
    output valid, has_keyboard, has_cons_page, has_desktop, id_count,
           report_id_0, report_id_1, report_id_2, report_id_3,
           report_id_4, report_id_5, report_id_6, report_id_7,
    input  ready
  );
  modport sink (
    input  valid, has_keyboard, has_cons_page, has_desktop, id_count,
           report_id_0, report_id_1, report_id_2, report_id_3,
           report_id_4, report_id_5, report_id_6, report_id_7,
    output ready
  );
endinterface

@@ rtl/core/hid_descriptor_item_scanner.sv @@
// Top level of the HID report descriptor short item scanner.
//
// The scanner takes one descriptor byte per cycle while its input is not
// stalled: a byte is registered at the input, then decoded against the item
// parser state, and a summary for a byte marked last is loaded into an output
// register, which offers it as the result. The input register only stalls
// while a summary is due and the output register still holds an earlier
// summary that has not been taken. Findings (usage page flags and up to
// MAX_IDS report IDs) are cleared by a byte marked first and persist
// otherwise; an item cut off by the last byte is dropped.
module hid_descriptor_item_scanner import hdis_pkg::*; #(
  parameter int unsigned MAX_IDS = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  hdis_byte_if.sink     desc_i,
  hdis_result_if.source scan_o
);

  // Input register
  logic  in_valid_q, in_valid_d;
  byte_t in_q;

  // Parser and findings state
  logic [2:0]        left_q, left_d;
  logic [1:0]        pos_q, pos_d;
  logic [1:0]        type_q, type_d;
  logic [3:0]        tag_q, tag_d;
  logic [ValueW-1:0] value_q, value_d;
  logic              kbd_q, kbd_d;
  logic              cons_q, cons_d;
  logic              desk_q, desk_d;
  logic [CountW-1:0] fill_q, fill_d;
  logic [ByteW-1:0]  id_q [StoreDepth];
  logic [ByteW-1:0]  id_d [StoreDepth];

  // Output register
  logic out_valid_q, out_valid_d;

  logic proc_fire;
  logic item_done;

  // Handshake: a byte is decoded unless its summary cannot be stored yet
  assign proc_fire    = in_valid_q && (!in_q.last_byte || !out_valid_q || scan_o.ready);
  assign desc_i.ready = !in_valid_q || proc_fire;
  assign in_valid_d   = desc_i.valid || (in_valid_q && !proc_fire);

  // Item decode and findings update
  always_comb begin
    left_d    = left_q;
    pos_d     = pos_q;
    type_d    = type_q;
    tag_d     = tag_q;
    value_d   = value_q;
    kbd_d     = kbd_q;
    cons_d    = cons_q;
    desk_d    = desk_q;
    fill_d    = fill_q;
    id_d      = id_q;
    item_done = 1'b0;

    if (in_q.first_byte) begin
      left_d  = '0;
      pos_d   = '0;
      type_d  = '0;
      tag_d   = '0;
      value_d = '0;
      kbd_d   = 1'b0;
      cons_d  = 1'b0;
      desk_d  = 1'b0;
      fill_d  = '0;
      for (int k = 0; k < StoreDepth; k++) begin
        id_d[k] = '0;
      end
    end

    if (left_d == 3'd0) begin
      // prefix byte
      type_d    = in_q.desc_byte[3:2];
      tag_d     = in_q.desc_byte[7:4];
      value_d   = '0;
      pos_d     = '0;
      left_d    = (in_q.desc_byte[1:0] == SIZE_CODE_FOUR) ? DATA_BYTES_MAX
                                                          : {1'b0, in_q.desc_byte[1:0]};
      item_done = (in_q.desc_byte[1:0] == 2'd0);
    end else begin
      // data byte, little endian; bytes above the low 16 bits are not kept
      case (pos_d)
        2'd0:    value_d[7:0]  = in_q.desc_byte;
        2'd1:    value_d[15:8] = in_q.desc_byte;
        default: ;
      endcase
      pos_d     = pos_d + 2'd1;
      left_d    = left_d - 3'd1;
      item_done = (left_d == 3'd0);
    end

    // complete Global item
    if (item_done && type_d == ITEM_TYPE_GLOBAL) begin
      if (tag_d == TAG_USAGE_PAGE) begin
        if (value_d == PAGE_KEYBOARD) kbd_d  = 1'b1;
        if (value_d == PAGE_CONSUMER) cons_d = 1'b1;
        if (value_d == PAGE_DESKTOP)  desk_d = 1'b1;
      end else if (tag_d == TAG_REPORT_ID) begin
        if (fill_d < CountW'(MAX_IDS)) begin
          id_d[fill_d[IdxW-1:0]] = value_d[ByteW-1:0];
          fill_d                 = fill_d + CountW'(1);
        end
      end
    end

    // last byte drops any pending item
    if (in_q.last_byte) begin
      left_d  = '0;
      pos_d   = '0;
      type_d  = '0;
      tag_d   = '0;
      value_d = '0;
    end
  end

  // Output valid: set by a summary, cleared by its transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (proc_fire && in_q.last_byte) begin
      out_valid_d = 1'b1;
    end else if (scan_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      pos_q       <= '0;
      type_q      <= '0;
      tag_q       <= '0;
      value_q     <= '0;
      kbd_q       <= 1'b0;
      cons_q      <= 1'b0;
      desk_q      <= 1'b0;
      fill_q      <= '0;
      for (int k = 0; k < StoreDepth; k++) begin
        id_q[k] <= '0;
      end
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (proc_fire) begin
        left_q  <= left_d;
        pos_q   <= pos_d;
        type_q  <= type_d;
        tag_q   <= tag_d;
        value_q <= value_d;
        kbd_q   <= kbd_d;
        cons_q  <= cons_d;
        desk_q  <= desk_d;
        fill_q  <= fill_d;
        id_q    <= id_d;
      end
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (desc_i.valid && desc_i.ready) begin
      in_q.desc_byte  <= desc_i.desc_byte;
      in_q.first_byte <= desc_i.first_byte;
      in_q.last_byte  <= desc_i.last_byte;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (proc_fire && in_q.last_byte) begin
      scan_o.has_keyboard  <= kbd_d;
      scan_o.has_cons_page <= cons_d;
      scan_o.has_desktop   <= desk_d;
      scan_o.id_count      <= fill_d;
      scan_o.report_id_0   <= id_d[0];
      scan_o.report_id_1   <= id_d[1];
      scan_o.report_id_2   <= id_d[2];
      scan_o.report_id_3   <= id_d[3];
      scan_o.report_id_4   <= id_d[4];
      scan_o.report_id_5   <= id_d[5];
      scan_o.report_id_6   <= id_d[6];
      scan_o.report_id_7   <= id_d[7];
    end
  end

  assign scan_o.valid = out_valid_q;

endmodule

@@ rtl/core/hdis_checker.sv @@
// Port-level checks of the descriptor item scanner, bound to its top level.
module hdis_checker import hdis_pkg::*; #(
  parameter int unsigned MAX_IDS = 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [CountW-1:0]           id_count_i,
  input logic [StoreDepth*ByteW-1:0] report_ids_i
);

  // A summary never reports more IDs than the list holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (id_count_i <= CountW'(MAX_IDS)))
    else $error("id_count exceeds the report ID list size");

  // Slots past the ID count read as zero
  for (genvar k = 0; k < StoreDepth; k++) begin : g_slot
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_i && (id_count_i <= CountW'(k)))
        |-> (report_ids_i[k*ByteW +: ByteW] == '0))
      else $error("unused report ID slot is not zero");
  end

  // A stalled summary stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("summary dropped while stalled");

endmodule

bind hid_descriptor_item_scanner hdis_checker #(.MAX_IDS(MAX_IDS)) u_hdis_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (scan_o.valid),
  .out_ready_i  (scan_o.ready),
  .id_count_i   (scan_o.id_count),
  .report_ids_i ({scan_o.report_id_7, scan_o.report_id_6, scan_o.report_id_5,
                  scan_o.report_id_4, scan_o.report_id_3, scan_o.report_id_2,
                  scan_o.report_id_1, scan_o.report_id_0})
);

@@ test/hid_descriptor_item_scanner_tb.sv @@
// Self-checking testbench of the HID report descriptor short item scanner.
module hid_descriptor_item_scanner_tb import hdis_pkg::*; ();

  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned TimeoutCycles = 200000;
  localparam int unsigned RandomBytes   = 1350;
  localparam int unsigned MaxIds        = 8;

  // Item types that the scanner skips
  localparam logic [1:0] TYPE_MAIN     = 2'h0;
  localparam logic [1:0] TYPE_LOCAL    = 2'h2;
  localparam logic [1:0] TYPE_RESERVED = 2'h3;

  // Findings reported for a descriptor
  typedef struct {
    logic              keyboard;
    logic              consumer;
    logic              desktop;
    logic [CountW-1:0] id_count;
    logic [ByteW-1:0]  ids [StoreDepth];
  } summary_t;

  // Tracks the item parser and findings, and checks each summary against them
  class descriptor_summary_checker;
    logic [2:0]       data_left;
    logic [1:0]       data_pos;
    logic [1:0]       pend_type;
    logic [3:0]       pend_tag;
    logic [31:0]      pend_value;
    logic [2:0]       pages;
    logic [ByteW-1:0] ids [StoreDepth];
    int unsigned      fill;
    summary_t         due_summaries [$];
    int unsigned      errors;

    function new();
      clear_parser();
      clear_findings();
      errors = 0;
    endfunction

    function void clear_parser();
      data_left  = '0;
      data_pos   = '0;
      pend_type  = '0;
      pend_tag   = '0;
      pend_value = '0;
    endfunction

    function void clear_findings();
      pages = '0;
      foreach (ids[k]) ids[k] = '0;
      fill = 0;
    endfunction

    // Apply a complete item; only global usage page and report ID matter
    function void close_item();
      logic [ValueW-1:0] page;
      if (pend_type != ITEM_TYPE_GLOBAL) return;
      if (pend_tag == TAG_USAGE_PAGE) begin
        page = pend_value[ValueW-1:0];
        if (page == PAGE_KEYBOARD) pages[0] = 1'b1;
        if (page == PAGE_CONSUMER) pages[1] = 1'b1;
        if (page == PAGE_DESKTOP)  pages[2] = 1'b1;
      end else if (pend_tag == TAG_REPORT_ID && fill < MaxIds) begin
        ids[fill] = pend_value[ByteW-1:0];
        fill++;
      end
    endfunction

    // One accepted descriptor byte
    function void take_byte(byte_t b);
      summary_t s;
      if (b.first_byte) begin
        clear_parser();
        clear_findings();
      end
      if (data_left == 0) begin
        pend_type  = b.desc_byte[3:2];
        pend_tag   = b.desc_byte[7:4];
        pend_value = '0;
        data_pos   = '0;
        data_left  = (b.desc_byte[1:0] == SIZE_CODE_FOUR) ? DATA_BYTES_MAX
                                                          : {1'b0, b.desc_byte[1:0]};
        if (data_left == 0) close_item();
      end else begin
        pend_value[{data_pos, 3'b000} +: 8] = b.desc_byte;
        data_pos  = data_pos + 2'd1;
        data_left = data_left - 3'd1;
        if (data_left == 0) close_item();
      end
      if (b.last_byte) begin
        // a cut-off item is dropped here
        clear_parser();
        s.keyboard = pages[0];
        s.consumer = pages[1];
        s.desktop  = pages[2];
        s.id_count = fill[CountW-1:0];
        s.ids      = ids;
        due_summaries.push_back(s);
      end
    endfunction

    function void report_mismatch(string field, logic [ByteW-1:0] want, logic [ByteW-1:0] got);
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      errors++;
    endfunction

    // One summary transfer from the scanner
    function void check_summary(summary_t got);
      summary_t want;
      if (due_summaries.size() == 0) begin
        $display("%0t: summary with id_count %0d, expected none", $time, got.id_count);
        errors++;
        return;
      end
      want = due_summaries.pop_front();
      if (got.keyboard !== want.keyboard)
        report_mismatch("has_keyboard", want.keyboard, got.keyboard);
      if (got.consumer !== want.consumer)
        report_mismatch("has_cons_page", want.consumer, got.consumer);
      if (got.desktop !== want.desktop)
        report_mismatch("has_desktop", want.desktop, got.desktop);
      if (got.id_count !== want.id_count)
        report_mismatch("id_count", want.id_count, got.id_count);
      foreach (want.ids[k])
        if (got.ids[k] !== want.ids[k])
          report_mismatch($sformatf("report_id_%0d", k), want.ids[k], got.ids[k]);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hdis_byte_if   desc_if ();
  hdis_result_if scan_if ();

  hid_descriptor_item_scanner #(
    .MAX_IDS (MaxIds)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .desc_i (desc_if),
    .scan_o (scan_if)
  );

  descriptor_summary_checker tracker = new();

  byte_t       desc_bytes [$];
  int unsigned burst_left = 0;

  // Directed descriptors: both marks on a zero-size report ID, every page flag
  // (the desktop one through a four-byte value with a nonzero upper half), a main
  // item, a reserved item with four data bytes, an item cut off by the last byte,
  // and a descriptor that carries on without a first mark
  byte_t directed_bytes [23] = '{
    '{8'h84, 1'b1, 1'b1},
    '{8'h05, 1'b1, 1'b0}, '{8'h07, 1'b0, 1'b0},
    '{8'h06, 1'b0, 1'b0}, '{8'h0C, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
    '{8'h07, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0}, '{8'h85, 1'b0, 1'b0}, '{8'h11, 1'b0, 1'b0},
    '{8'h22, 1'b0, 1'b0}, '{8'h33, 1'b0, 1'b0},
    '{8'h85, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
    '{8'h86, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b1},
    '{8'h85, 1'b0, 1'b0}, '{8'h03, 1'b0, 1'b1}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("hid_descriptor_item_scanner_tb failed");
    $finish;
  end

  function automatic void push_byte(logic [7:0] b);
    desc_bytes.push_back('{desc_byte: b, first_byte: 1'b0, last_byte: 1'b0});
  endfunction

  // One short item with random content; report IDs dominate when id_heavy is set
  function automatic void append_item(bit id_heavy);
    int unsigned pick;
    int unsigned nbytes;
    logic [1:0]  code;
    logic [1:0]  ityp;
    logic [3:0]  itag;
    logic [31:0] value;
    pick  = $urandom_range(99);
    code  = 2'($urandom_range(3));
    value = $urandom;
    ityp  = ITEM_TYPE_GLOBAL;
    if (pick < (id_heavy ? 80 : 30)) begin
      itag = TAG_REPORT_ID;
    end else if (pick < (id_heavy ? 90 : 60)) begin
      itag = TAG_USAGE_PAGE;
      case ($urandom_range(4))
        0: value[ValueW-1:0] = PAGE_KEYBOARD;
        1: value[ValueW-1:0] = PAGE_CONSUMER;
        2: value[ValueW-1:0] = PAGE_DESKTOP;
        // a page of interest in the low byte, spoiled above it
        3: value[ValueW-1:0] = PAGE_CONSUMER | ValueW'($urandom_range(1, 255) << 8);
        default: ;
      endcase
    end else if (pick < (id_heavy ? 95 : 75)) begin
      itag = 4'($urandom);
    end else begin
      itag = 4'($urandom);
      case ($urandom_range(2))
        0:       ityp = TYPE_MAIN;
        1:       ityp = TYPE_LOCAL;
        default: ityp = TYPE_RESERVED;
      endcase
    end
    push_byte({itag, ityp, code});
    nbytes = (code == SIZE_CODE_FOUR) ? 4 : 32'(code);
    for (int k = 0; k < nbytes; k++) push_byte(value[8*k +: 8]);
  endfunction

  // A well-formed descriptor, sometimes without a first mark or cut short
  function automatic void build_descriptor();
    int unsigned n_items;
    int unsigned last_start;
    int unsigned keep;
    bit          id_heavy;
    desc_bytes.delete();
    id_heavy   = ($urandom_range(9) == 0);
    n_items    = id_heavy ? $urandom_range(9, 14) : $urandom_range(1, 8);
    last_start = 0;
    for (int i = 0; i < n_items; i++) begin
      last_start = desc_bytes.size();
      append_item(id_heavy);
    end
    if ($urandom_range(4) == 0 && desc_bytes.size() - last_start >= 2) begin
      keep = $urandom_range(last_start + 1, desc_bytes.size() - 1);
      while (desc_bytes.size() > keep) void'(desc_bytes.pop_back());
    end
    desc_bytes[0].first_byte = ($urandom_range(7) != 0);
    desc_bytes[desc_bytes.size()-1].last_byte = 1'b1;
  endfunction

  // Raw bytes with marks thrown in at random
  function automatic void build_noise();
    int unsigned n;
    desc_bytes.delete();
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++)
      desc_bytes.push_back('{desc_byte:  8'($urandom),
                             first_byte: ($urandom_range(5) == 0),
                             last_byte:  ($urandom_range(5) == 0)});
  endfunction

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      desc_if.valid      <= 1'b0;
      desc_if.desc_byte  <= 8'($urandom);
      desc_if.first_byte <= 1'($urandom);
      desc_if.last_byte  <= 1'($urandom);
    end
  endtask

  // Present one byte and hold it until the scanner takes it
  task automatic send_byte(byte_t b);
    @(negedge clk_i);
    desc_if.valid      <= 1'b1;
    desc_if.desc_byte  <= b.desc_byte;
    desc_if.first_byte <= b.first_byte;
    desc_if.last_byte  <= b.last_byte;
    do @(posedge clk_i); while (!desc_if.ready);
    tracker.take_byte(b);
  endtask

  // Send the queued bytes in bursts, with a gap before most of them
  task automatic send_descriptor();
    int unsigned gap;
    foreach (desc_bytes[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) idle_cycles(gap);
        burst_left = $urandom_range(1, 30);
      end
      send_byte(desc_bytes[i]);
      burst_left--;
    end
  endtask

  // Result side: ready runs broken by stalls of random length
  initial begin
    int unsigned open_run;
    int unsigned stall_run;
    scan_if.ready = 1'b0;
    open_run  = 0;
    stall_run = 0;
    forever begin
      @(negedge clk_i);
      if (open_run == 0 && stall_run == 0) begin
        open_run  = $urandom_range(1, 40);
        stall_run = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (stall_run > 0) begin
        scan_if.ready <= 1'b0;
        stall_run--;
      end else begin
        scan_if.ready <= 1'b1;
        open_run--;
      end
    end
  end

  // Summary transfers
  always @(posedge clk_i) begin
    summary_t got;
    if (rst_ni && scan_if.valid && scan_if.ready) begin
      got.keyboard = scan_if.has_keyboard;
      got.consumer = scan_if.has_cons_page;
      got.desktop  = scan_if.has_desktop;
      got.id_count = scan_if.id_count;
      got.ids[0]   = scan_if.report_id_0;
      got.ids[1]   = scan_if.report_id_1;
      got.ids[2]   = scan_if.report_id_2;
      got.ids[3]   = scan_if.report_id_3;
      got.ids[4]   = scan_if.report_id_4;
      got.ids[5]   = scan_if.report_id_5;
      got.ids[6]   = scan_if.report_id_6;
      got.ids[7]   = scan_if.report_id_7;
      tracker.check_summary(got);
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned sent;
    rst_ni             = 1'b0;
    desc_if.valid      = 1'b0;
    desc_if.desc_byte  = '0;
    desc_if.first_byte = 1'b0;
    desc_if.last_byte  = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    desc_bytes.delete();
    foreach (directed_bytes[k]) desc_bytes.push_back(directed_bytes[k]);
    send_descriptor();

    sent = 0;
    while (sent < RandomBytes) begin
      if ($urandom_range(7) == 0) build_noise();
      else build_descriptor();
      sent += desc_bytes.size();
      send_descriptor();
    end
    idle_cycles(1);

    // drain, then allow for the output pipeline
    while (tracker.due_summaries.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.due_summaries.size() == 0) begin
      $display("hid_descriptor_item_scanner_tb passed");
    end else begin
      $display("hid_descriptor_item_scanner_tb failed");
    end
    $finish;
  end

endmodule
